// ----- sv/bic_pkg.sv -----
// ----------------------------------------------------------------------------
// bic_pkg: shared types and constants
// Opcodes, controller states, memory size and the command/status structs
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bic_pkg;

  typedef enum logic [3:0] {
    OP_NOP0 = 4'h0, OP_ADD = 4'h1, OP_AND = 4'h2, OP_DIV = 4'h3,
    OP_MUL  = 4'h4, OP_SUB = 4'h5, OP_OR  = 4'h6, OP_SHF = 4'h7,
    OP_INT  = 4'h8, OP_ADDI = 4'h9, OP_BEQ = 4'hA, OP_BLT = 4'hB,
    OP_JMP  = 4'hC, OP_ITER = 4'hD, OP_LDW = 4'hE, OP_STW = 4'hF
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_DIV, S_MEMRD, S_MEMWR, S_DONE, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       start_step;  // accept a beat
    logic       fetch;       // address pc + cnt, capture byte cnt - 1
    logic       decode;      // latch operands
    logic       exec;        // execute
    logic       div_step;    // one divider iteration
    logic       mem_rd;      // address data byte cnt, capture byte cnt - 1
    logic       mem_wr;      // write data byte cnt
    logic       finish;      // commit register/pc, build result
    logic [2:0] cnt;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    is_load;
    logic    halt;
    opcode_t op;
    logic    div_zero;
    logic    div_done;
  } sts_t;

  localparam int DIV_BITS  = 32;
  localparam int MEM_BYTES = 1024;

endpackage

// ----- sv/bic_ctrl.sv -----
// ----------------------------------------------------------------------------
// bic_ctrl: instruction sequencer
// Steps each beat through fetch, decode, execute, divide or memory, and result phases.
// ----------------------------------------------------------------------------
module bic_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  bic_pkg::sts_t sts,
  output bic_pkg::cmd_t cmd
);
  import bic_pkg::*;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state; memory reads are registered, so a read phase ends with a
  // step that only captures the byte from its last address
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: if (in_tvalid) begin
        state_next = S_FETCH;
        cnt_next   = '0;
      end
      S_FETCH: begin
        if (sts.is_load) state_next = S_DONE;
        else if (cnt == 3'd4) state_next = S_DECODE;
        else cnt_next = cnt + 3'd1;
      end
      S_DECODE: begin
        cnt_next = '0;
        if (sts.halt) state_next = S_DONE;
        else if (sts.op == OP_DIV) state_next = sts.div_zero ? S_DONE : S_DIV;
        else if (sts.op == OP_LDW || sts.op == OP_ITER) state_next = S_MEMRD;
        else if (sts.op == OP_STW) state_next = S_MEMWR;
        else state_next = S_EXEC;
      end
      S_EXEC: state_next = S_DONE;
      S_DIV: if (sts.div_done) state_next = S_DONE;
      S_MEMRD: begin
        if ((sts.op == OP_ITER && cnt == 3'd1) || cnt == 3'd4) state_next = S_DONE;
        else cnt_next = cnt + 3'd1;
      end
      S_MEMWR: begin
        if (cnt == 3'd3) state_next = S_DONE;
        else cnt_next = cnt + 3'd1;
      end
      S_DONE: state_next = S_OUT;
      S_OUT: if (out_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.cnt        = cnt;
    in_tready      = (state == S_IDLE);
    out_tvalid     = (state == S_OUT);
    cmd.start_step = (state == S_IDLE) && in_tvalid;
    cmd.fetch      = (state == S_FETCH);
    cmd.decode     = (state == S_DECODE);
    cmd.exec       = (state == S_EXEC);
    cmd.div_step   = (state == S_DIV);
    cmd.mem_rd     = (state == S_MEMRD);
    cmd.mem_wr     = (state == S_MEMWR);
    cmd.finish     = (state == S_DONE);
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_tvalid) else $error("finish not followed by result");
`endif

endmodule

// ----- sv/bic_dpath.sv -----
// ----------------------------------------------------------------------------
// bic_dpath: processor datapath
// Byte memory, register file, ALU, serial divider and result register.
// ----------------------------------------------------------------------------
module bic_dpath (
  input  logic          clk,
  input  logic          rst,
  input  logic          mode,
  input  logic [9:0]    load_addr,
  input  logic [7:0]    load_byte,
  input  bic_pkg::cmd_t cmd,
  output bic_pkg::sts_t sts,
  output logic [9:0]    pc_now,
  output logic          halted,
  output logic          fault,
  output logic          reg_written,
  output logic [3:0]    reg_index,
  output logic [31:0]   reg_value,
  output logic          mem_written,
  output logic [9:0]    mem_addr,
  output logic [31:0]   mem_word
);
  import bic_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  // address modulo MEM_BYTES, a power of two: keep the low bits
  function automatic logic [AW-1:0] wrap(input logic [31:0] a);
    wrap = a[AW-1:0];
  endfunction

  logic [7:0]   mem [MEM_BYTES];
  logic [31:0]  rf [16];
  logic [AW-1:0] pc;

  logic          mode_q;
  logic [9:0]    laddr_q;
  logic [7:0]    lbyte_q;
  logic [7:0]    ib [4];
  logic [31:0]   va, vb, rval, daddr, mword_q;
  logic          rw, mw, flt, hlt;
  logic [3:0]    ridx;
  logic [31:0]   next_pc;

  // divider
  logic [31:0]   dq, dr, dd;
  logic [5:0]    dcnt;
  logic          dneg;

  // memory address for the current phase
  logic [AW-1:0] maddr_c;
  logic [7:0]    rdata;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  opcode_t op;
  assign op = opcode_t'(ib[0][7:4]);

  always_comb begin
    maddr_c = wrap(32'(pc) + 32'(cmd.cnt));
    if (cmd.mem_rd && op == OP_ITER) maddr_c = wrap(va + 32'(ib[1]));
    else if (cmd.mem_rd || cmd.mem_wr) maddr_c = wrap(daddr + 32'(cmd.cnt));
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = maddr_c;
    mem_wd = 8'(va >> (5'd24 - 5'(cmd.cnt) * 5'd8));
    if (cmd.fetch && mode_q == 1'b0) begin
      mem_we = 1'b1;
      mem_wa = laddr_q[AW-1:0] & AW'(MEM_BYTES - 1);
      mem_wd = lbyte_q;
    end else if (cmd.mem_wr) begin
      mem_we = 1'b1;
    end
  end

  // memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[maddr_c];
  end

  // register file, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) rf[i] <= '0;
    end else if (cmd.finish && rw) begin
      rf[ridx] <= rval;
    end
  end

  assign sts.is_load  = !mode_q;
  assign sts.halt     = (ib[0] == 8'd0);
  assign sts.op       = op;
  assign sts.div_zero = (rf[ib[1][7:4]] == 32'd0);
  assign sts.div_done = (dcnt == 6'd0);

  // sequenced datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      if (cmd.start_step) begin
        mode_q  <= mode;
        laddr_q <= load_addr;
        lbyte_q <= load_byte;
        rw <= 1'b0; mw <= 1'b0; flt <= 1'b0; hlt <= 1'b0;
        ridx <= '0; rval <= '0; mword_q <= '0; daddr <= '0;
      end
      // read data arrives in the cycle after its address
      if (cmd.fetch && cmd.cnt != 3'd0) ib[2'(cmd.cnt - 3'd1)] <= rdata;
      if (cmd.decode) begin
        va      <= rf[ib[0][3:0]];
        vb      <= rf[ib[1][7:4]];
        hlt     <= (ib[0] == 8'd0);
        next_pc <= 32'(pc) + 32'd2;
        daddr   <= rf[ib[1][7:4]] + 32'(ib[1][3:0]);
        if (op == OP_DIV) begin
          rw   <= 1'b1;
          ridx <= ib[1][3:0];
          if (sts.div_zero) begin
            flt <= 1'b1; rval <= '0;
          end
          // magnitudes for the restoring divider
          dq   <= rf[ib[0][3:0]][31] ? -rf[ib[0][3:0]] : rf[ib[0][3:0]];
          dd   <= rf[ib[1][7:4]][31] ? -rf[ib[1][7:4]] : rf[ib[1][7:4]];
          dneg <= rf[ib[0][3:0]][31] ^ rf[ib[1][7:4]][31];
          dr   <= '0;
          dcnt <= 6'(DIV_BITS);
        end
      end
      if (cmd.exec) begin
        case (op)
          OP_ADD:  begin rw <= 1'b1; ridx <= ib[1][3:0]; rval <= va + vb; end
          OP_AND:  begin rw <= 1'b1; ridx <= ib[1][3:0]; rval <= va & vb; end
          OP_MUL:  begin rw <= 1'b1; ridx <= ib[1][3:0]; rval <= va * vb; end
          OP_SUB:  begin rw <= 1'b1; ridx <= ib[1][3:0]; rval <= va - vb; end
          OP_OR:   begin rw <= 1'b1; ridx <= ib[1][3:0]; rval <= va | vb; end
          OP_SHF: begin
            rw <= 1'b1; ridx <= ib[0][3:0];
            rval <= ib[1][5] ? 32'($signed(va) >>> ib[1][4:0]) : va << ib[1][4:0];
          end
          OP_ADDI: begin
            rw <= 1'b1; ridx <= ib[0][3:0];
            rval <= va + {{24{ib[1][7]}}, ib[1]};
          end
          OP_BEQ: next_pc <= 32'(pc) + ((va == vb)
                   ? {12'd0, ib[1][3:0], ib[2], ib[3]} : 32'd4);
          OP_BLT: next_pc <= 32'(pc) + (($signed(va) < $signed(vb))
                   ? {12'd0, ib[1][3:0], ib[2], ib[3]} : 32'd4);
          OP_JMP: next_pc <= {4'd0, ib[0][3:0], ib[1], ib[2], ib[3]};
          default: ;
        endcase
      end
      // one restoring step per cycle
      if (cmd.div_step && dcnt != 6'd0) begin
        if ({dr[30:0], dq[31]} >= dd) begin
          dr <= {dr[30:0], dq[31]} - dd;
          dq <= {dq[30:0], 1'b1};
        end else begin
          dr <= {dr[30:0], dq[31]};
          dq <= {dq[30:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
      end
      if (cmd.div_step && dcnt == 6'd0) rval <= dneg ? -dq : dq;
      if (cmd.mem_rd) begin
        if (op == OP_ITER) begin
          if (cmd.cnt == 3'd1) begin
            if (rdata != 8'd0) begin
              rw <= 1'b1; ridx <= ib[0][3:0]; rval <= {24'd0, rdata};
              next_pc <= 32'(pc) - {16'd0, ib[2], ib[3]};
            end else begin
              next_pc <= 32'(pc) + 32'd4;
            end
          end
        end else if (cmd.cnt != 3'd0) begin
          rw <= 1'b1; ridx <= ib[0][3:0];
          rval <= {rval[23:0], rdata};
        end
      end
      if (cmd.mem_wr) begin
        mw <= 1'b1; mword_q <= va;
      end
      if (cmd.finish && mode_q && !hlt) pc <= wrap(next_pc);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pc_now      <= 10'((mode_q && !hlt) ? 32'(wrap(next_pc)) : 32'(pc));
      halted      <= mode_q && hlt;
      fault       <= flt;
      reg_written <= rw;
      reg_index   <= rw ? ridx : 4'd0;
      reg_value   <= rw ? rval : 32'd0;
      mem_written <= mw;
      mem_addr    <= mw ? 10'(wrap(daddr)) : 10'd0;
      mem_word    <= mw ? mword_q : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && dcnt != 6'd0 |=> dcnt == $past(dcnt) - 6'd1)
    else $error("divider count slipped");
  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rw && mw)) else $error("register and store in one step");
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> pc == $past(pc)) else $error("pc moved outside commit");
`endif

endmodule

// ----- sv/byte_isa_cpu_core.sv -----
// ----------------------------------------------------------------------------
// byte_isa_cpu_core: small 32-bit processor, one instruction per beat
// Sequencer plus datapath; memory byte writes and instruction steps.
// ----------------------------------------------------------------------------
// A beat with mode 0 writes one program byte; a beat with mode 1 runs one
// instruction: fetch of four bytes through the registered memory read port,
// a decode state, then execute, data memory or divider states, a commit
// state and the result. Halt and divide by zero go from decode straight to
// commit; divide runs on the one-bit-per-cycle restoring divider. One beat
// is in flight at a time and the result register holds until taken.
module byte_isa_cpu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // mode[0], load_addr[10:1], load_byte[18:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // pc_now, halted, fault, reg_written,
                                 // reg_index, reg_value, mem_written,
                                 // mem_addr, mem_word
);
  import bic_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [9:0]  pc_now, mem_addr;
  logic        halted, fault, reg_written, mem_written;
  logic [3:0]  reg_index;
  logic [31:0] reg_value, mem_word;

  bic_ctrl u_ctrl (
    .clk, .rst, .in_tvalid(s_tvalid), .in_tready(s_tready),
    .out_tvalid(m_tvalid), .out_tready(m_tready), .sts, .cmd
  );

  bic_dpath u_dp (
    .clk, .rst, .mode(s_tdata[0]), .load_addr(s_tdata[10:1]),
    .load_byte(s_tdata[18:11]), .cmd, .sts, .pc_now, .halted, .fault,
    .reg_written, .reg_index, .reg_value, .mem_written, .mem_addr, .mem_word
  );

  assign m_tdata = {4'd0, mem_word, mem_addr, mem_written, reg_value,
                    reg_index, reg_written, fault, halted, pc_now};

endmodule

// ----- bench/byte_isa_cpu_core_tb.sv -----
// ----------------------------------------------------------------------------
// byte_isa_cpu_core_tb: self-checking bench for the byte ISA processor core
// Fills program memory, runs directed instructions for each opcode and the
// corner cases, then mixed random programs. A scoreboard class predicts
// every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module byte_isa_cpu_core_tb;
  import bic_pkg::*;

  // One result beat, unpacked
  typedef struct {
    logic [9:0]  pc_now;
    logic        halted;
    logic        fault;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [9:0]  mem_addr;
    logic [31:0] mem_word;
  } cpu_result_t;

  // Predicts the core and holds pending results in order
  class cpu_scoreboard;
    logic [7:0]  mem_img [1024];
    logic [31:0] regs [16];
    logic [9:0]  pc;
    cpu_result_t pending [$];
    int          errors;

    function new();
      pc = '0;
      errors = 0;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem_img[i]) mem_img[i] = '0;
    endfunction

    function logic [7:0] rd(logic [31:0] a);
      return mem_img[a[9:0]];
    endfunction

    // Accepted input beat: run it on the shadow state
    function void note_beat(logic mode, logic [9:0] laddr, logic [7:0] lbyte);
      cpu_result_t r;
      logic [7:0]  b0, b1, b2, b3, m;
      logic [31:0] va, vb, addr, n;
      logic [9:0]  nxt;
      r = '{default: '0};
      if (!mode) begin
        mem_img[laddr] = lbyte;
      end else begin
        b0 = rd(pc);
        b1 = rd(pc + 1);
        b2 = rd(pc + 2);
        b3 = rd(pc + 3);
        if (b0 == 8'h00) begin
          r.halted = 1'b1;
        end else begin
          va = regs[b0[3:0]];
          vb = regs[b1[7:4]];
          nxt = pc + 10'd2;
          case (opcode_t'(b0[7:4]))
            OP_ADD, OP_AND, OP_DIV, OP_MUL, OP_SUB, OP_OR: begin
              case (opcode_t'(b0[7:4]))
                OP_ADD: r.reg_value = va + vb;
                OP_AND: r.reg_value = va & vb;
                OP_DIV: begin
                  if (vb == 0) begin
                    r.reg_value = '0;
                    r.fault = 1'b1;
                  end else if (va == 32'h8000_0000 && vb == 32'hFFFF_FFFF) begin
                    r.reg_value = va;
                  end else begin
                    r.reg_value = $signed(va) / $signed(vb);
                  end
                end
                OP_MUL: r.reg_value = va * vb;
                OP_SUB: r.reg_value = va - vb;
                default: r.reg_value = va | vb;
              endcase
              r.reg_written = 1'b1;
              r.reg_index = b1[3:0];
            end
            OP_SHF: begin
              if (!b1[5]) r.reg_value = va << b1[4:0];
              else r.reg_value = $signed(va) >>> b1[4:0];
              r.reg_written = 1'b1;
              r.reg_index = b0[3:0];
            end
            OP_ADDI: begin
              r.reg_value = va + {{24{b1[7]}}, b1};
              r.reg_written = 1'b1;
              r.reg_index = b0[3:0];
            end
            OP_BEQ, OP_BLT: begin
              n = {12'h0, b1[3:0], b2, b3};
              if (opcode_t'(b0[7:4]) == OP_BEQ ? (va == vb) : ($signed(va) < $signed(vb)))
                nxt = pc + n[9:0];
              else
                nxt = pc + 10'd4;
            end
            OP_JMP: nxt = {b2[1:0], b3};
            OP_ITER: begin
              m = rd(va + {24'h0, b1});
              if (m != 0) begin
                r.reg_value = {24'h0, m};
                r.reg_written = 1'b1;
                r.reg_index = b0[3:0];
                nxt = pc - {b2[1:0], b3};
              end else begin
                nxt = pc + 10'd4;
              end
            end
            OP_LDW: begin
              addr = vb + {28'h0, b1[3:0]};
              r.reg_value = {rd(addr), rd(addr + 1), rd(addr + 2), rd(addr + 3)};
              r.reg_written = 1'b1;
              r.reg_index = b0[3:0];
            end
            OP_STW: begin
              addr = vb + {28'h0, b1[3:0]};
              mem_img[addr[9:0]] = va[31:24];
              mem_img[addr[9:0] + 10'd1] = va[23:16];
              mem_img[addr[9:0] + 10'd2] = va[15:8];
              mem_img[addr[9:0] + 10'd3] = va[7:0];
              r.mem_written = 1'b1;
              r.mem_addr = addr[9:0];
              r.mem_word = va;
            end
            default: ;
          endcase
          if (r.reg_written) regs[r.reg_index] = r.reg_value;
          pc = nxt;
        end
      end
      r.pc_now = pc;
      pending.push_back(r);
    endfunction

    // Accepted result beat: compare with the oldest prediction
    function void check_beat(logic [95:0] d);
      cpu_result_t e, a;
      a.pc_now      = d[9:0];
      a.halted      = d[10];
      a.fault       = d[11];
      a.reg_written = d[12];
      a.reg_index   = d[16:13];
      a.reg_value   = d[48:17];
      a.mem_written = d[49];
      a.mem_addr    = d[59:50];
      a.mem_word    = d[91:60];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.pc_now != a.pc_now || e.halted != a.halted || e.fault != a.fault ||
          e.reg_written != a.reg_written || e.reg_index != a.reg_index ||
          e.reg_value != a.reg_value || e.mem_written != a.mem_written ||
          e.mem_addr != a.mem_addr || e.mem_word != a.mem_word) begin
        $display("%0t: mismatch expected pc=%h h=%b f=%b rw=%b ri=%h rv=%h mw=%b ma=%h md=%h",
                 $time, e.pc_now, e.halted, e.fault, e.reg_written, e.reg_index,
                 e.reg_value, e.mem_written, e.mem_addr, e.mem_word);
        $display("%0t:          actual   pc=%h h=%b f=%b rw=%b ri=%h rv=%h mw=%b ma=%h md=%h",
                 $time, a.pc_now, a.halted, a.fault, a.reg_written, a.reg_index,
                 a.reg_value, a.mem_written, a.mem_addr, a.mem_word);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;

  cpu_scoreboard sb = new();
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // receiver holds off for a long stretch

  byte_isa_cpu_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offer one beat, with a random gap first; note it once accepted
  task automatic send_beat(logic mode, logic [9:0] laddr, logic [7:0] lbyte);
    while (!quiet && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'h0, lbyte, laddr, mode};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(mode, laddr, lbyte);
  endtask

  // Write an instruction at the current pc, then execute it
  task automatic run_instr(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    logic [9:0] base;
    base = sb.pc;
    send_beat(1'b0, base, b0);
    send_beat(1'b0, base + 10'd1, b1);
    send_beat(1'b0, base + 10'd2, b2);
    send_beat(1'b0, base + 10'd3, b3);
    send_beat(1'b1, 10'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Result side: check accepted beats, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= 34);
    end
  end

  // Stimulus
  initial begin
    int k;
    logic [3:0] op;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every byte written so no step reads undefined memory
    for (k = 0; k < 1024; k++) send_beat(1'b0, 10'(k), 8'($urandom));

    // directed
    run_instr({OP_ADDI, 4'd1}, 8'h01, 8'h00, 8'h00);
    run_instr({OP_SHF, 4'd1}, 8'h1F, 8'h00, 8'h00);        // r1 = most negative
    run_instr({OP_ADDI, 4'd2}, 8'hFF, 8'h00, 8'h00);       // r2 = -1
    run_instr({OP_DIV, 4'd1}, {4'd2, 4'd3}, 8'h00, 8'h00); // divide overflow
    run_instr({OP_DIV, 4'd1}, {4'd0, 4'd4}, 8'h00, 8'h00); // divide by zero
    run_instr({OP_DIV, 4'd2}, {4'd1, 4'd9}, 8'h00, 8'h00);
    run_instr({OP_SHF, 4'd3}, 8'hE4, 8'h00, 8'h00);        // arith right, top bits set
    run_instr({OP_SHF, 4'd2}, 8'hC0, 8'h00, 8'h00);
    run_instr({OP_ADD, 4'd1}, {4'd2, 4'd5}, 8'h00, 8'h00);
    run_instr({OP_AND, 4'd1}, {4'd2, 4'd6}, 8'h00, 8'h00);
    run_instr({OP_MUL, 4'd2}, {4'd2, 4'd7}, 8'h00, 8'h00);
    run_instr({OP_SUB, 4'd0}, {4'd1, 4'd8}, 8'h00, 8'h00);
    run_instr({OP_OR, 4'd1}, {4'd2, 4'd10}, 8'h00, 8'h00);
    run_instr({OP_INT, 4'd0}, 8'h00, 8'h00, 8'h00);
    run_instr(8'h05, 8'hFF, 8'h00, 8'h00);                 // opcode zero, nonzero byte
    run_instr({OP_STW, 4'd2}, {4'd1, 4'hF}, 8'h00, 8'h00); // address wraps
    run_instr({OP_LDW, 4'd11}, {4'd1, 4'hF}, 8'h00, 8'h00);
    run_instr({OP_BEQ, 4'd0}, {4'd0, 4'h0}, 8'h00, 8'h08);
    run_instr({OP_BLT, 4'd1}, {4'd0, 4'hF}, 8'hFF, 8'hFF); // taken, far offset
    run_instr({OP_BLT, 4'd0}, {4'd1, 4'h0}, 8'h00, 8'h10); // not taken
    send_beat(1'b0, 10'h0F0, 8'h00);
    send_beat(1'b0, 10'h0F1, 8'h07);
    run_instr({OP_ITER, 4'd0}, 8'hF0, 8'h00, 8'h10);       // iterate miss
    run_instr({OP_ITER, 4'd0}, 8'hF1, 8'h00, 8'h10);       // iterate hit
    run_instr({OP_JMP, 4'hF}, 8'hFF, 8'hFF, 8'hFE);        // jump near the top
    run_instr({OP_ADDI, 4'd12}, 8'h80, 8'h00, 8'h00);      // fetch wraps
    run_instr(8'h00, 8'h00, 8'h00, 8'h00);                 // halt
    send_beat(1'b1, 10'h3FF, 8'hFF);                       // halts again

    // sender pauses until every result is in
    wait_drained();

    // random programs
    for (k = 0; k < 60; k++) begin
      if (k == 15) hold_req = 1'b1;
      quiet = (k >= 30 && k < 45);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          op = 4'($urandom);
          if (op == OP_NOP0 && $urandom_range(0, 1))
            run_instr(8'h00, 8'($urandom), 8'($urandom), 8'($urandom));
          else
            run_instr({op, 4'($urandom)}, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        11, 12, 13, 14, 15, 16: send_beat(1'b1, 10'($urandom), 8'($urandom));
        default: send_beat(1'b0, 10'($urandom), 8'($urandom));
      endcase
    end
    quiet = 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3200000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
